>>> design/cdrs_pkg.sv
package cdrs_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int NUM_W = 48;
  localparam int DEN_W = 32;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_FIND = 2'd1;
  localparam logic [1:0] OP_RATE = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_DIVTAB = 2'd1;
  localparam logic [1:0] MODE_FACTAB = 2'd2;
  localparam logic [1:0] MODE_FIXED  = 2'd3;

  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_FIELD_WIDTH = 3'd1;
  localparam logic [2:0] REG_ENTRY_COUNT = 3'd2;
  localparam logic [2:0] REG_FIXED_MUL   = 3'd3;
  localparam logic [2:0] REG_FIXED_DIV   = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  entry_index;
    logic [15:0] entry_setting;
    logic [15:0] entry_multiplier;
    logic [15:0] entry_divisor;
    logic [31:0] target_rate;
    logic [31:0] src_rate;
    logic [15:0] query_setting;
  } in_t;

  typedef struct packed {
    logic [31:0] rate_out;
    logic [15:0] setting_out;
    logic        setting_valid;
  } out_t;

  typedef struct packed {
    logic [15:0] setting;
    logic [15:0] mul;
    logic [15:0] dv;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> design/cdrs_div.sv
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module cdrs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cdrs_pkg::NUM_W-1:0] num,
  input  logic [cdrs_pkg::DEN_W-1:0] den,
  output logic [cdrs_pkg::NUM_W-1:0] quo,
  output cdrs_pkg::div_status_t      status
);

  localparam int STEP_W = $clog2(cdrs_pkg::NUM_W + 1);

  logic [cdrs_pkg::NUM_W-1:0] qn;
  logic [cdrs_pkg::DEN_W:0]   rem;
  logic [cdrs_pkg::DEN_W-1:0] dreg;
  logic [STEP_W-1:0]          steps;
  logic                       busy;
  logic                       done;

  logic [cdrs_pkg::DEN_W:0]   trial;
  logic [cdrs_pkg::DEN_W+1:0] diff;

  assign trial = {rem[cdrs_pkg::DEN_W-1:0], qn[cdrs_pkg::NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(cdrs_pkg::NUM_W);
        qn    <= num;
        dreg  <= den;
        rem   <= '0;
      end else if (busy) begin
        if (!diff[cdrs_pkg::DEN_W+1]) begin
          rem <= diff[cdrs_pkg::DEN_W:0];
          qn  <= {qn[cdrs_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          qn  <= {qn[cdrs_pkg::NUM_W-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo         = qn;
  assign status.busy = busy;
  assign status.done = done;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without a running divide");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |=> busy) else $error("divider not busy after start");
  a_step_count: assert property (@(posedge clk) disable iff (rst)
    (busy && !start) |-> (steps != '0)) else $error("divider step count underflow");

endmodule

>>> design/clock_divider_rate_solver_core.sv
// Work per accepted beat: load and unknown opcodes need no divide; fixed factor does one
// multiply and divide; plain lookup one divide, plain search two divides; table search
// one divide per entry (no multiply in divider table mode), up to 16 entries.
// One item at a time: in_stall is high from accept until the result is registered,
// so a new beat is taken only back in S_IDLE; the shared 48-step divider sets the rate.
// Synchronous reset restores config registers; table entries undefined until loaded.
module clock_divider_rate_solver_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  cdrs_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output cdrs_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_RD, S_ENT, S_MUL, S_DIV, S_WAIT, S_EVAL, S_FIN
  } state_t;

  state_t state;

  logic [1:0]  mode;
  logic [4:0]  field_width;
  logic [4:0]  entry_count;
  logic [15:0] fixed_multiplier;
  logic [15:0] fixed_divisor;

  cdrs_pkg::entry_t mem [cdrs_pkg::TABLE_DEPTH];
  cdrs_pkg::entry_t ent;

  logic [1:0]  op;
  logic [31:0] par;
  logic [31:0] tgt;
  logic [15:0] qset;
  logic [cdrs_pkg::CNT_W-1:0] cnt;
  logic [cdrs_pkg::CNT_W-1:0] n;
  logic        stage;
  logic [15:0] s_reg;
  logic [15:0] mul_m;
  logic [47:0] best_err;
  logic [47:0] top_rate;
  logic [15:0] best_set;
  logic [47:0] res_rate;
  logic [15:0] res_set;
  logic        res_valid;

  logic [cdrs_pkg::NUM_W-1:0] num_r;
  logic [cdrs_pkg::DEN_W-1:0] den_r;
  logic                       div_start;
  logic [cdrs_pkg::NUM_W-1:0] quo;
  cdrs_pkg::div_status_t      div_st;

  logic        accept;
  logic [4:0]  w;
  logic [15:0] lim;
  logic [47:0] dvm1;
  logic [15:0] s_calc;
  logic [47:0] err;
  logic [47:0] prod;
  logic [cdrs_pkg::CNT_W-1:0] cnt_inc;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  assign w      = (field_width > 5'd16) ? 5'd16 : field_width;
  assign lim    = 16'((17'd1 << w) - 17'd1);
  assign dvm1   = quo - 48'd1;
  assign s_calc = (quo == '0) ? 16'd0 : ((dvm1 > {32'd0, lim}) ? lim : dvm1[15:0]);
  assign err    = ({16'd0, tgt} > quo) ? ({16'd0, tgt} - quo) : (quo - {16'd0, tgt});
  assign prod   = par * mul_m;
  assign cnt_inc = cnt + 1'b1;

  cdrs_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (num_r),
    .den    (den_r),
    .quo    (quo),
    .status (div_st)
  );

  // table: written by a load beat, read through a registered port
  always_ff @(posedge clk) begin
    if (accept && in_data.opcode == cdrs_pkg::OP_LOAD &&
        32'(in_data.entry_index) < 32'(cdrs_pkg::TABLE_DEPTH)) begin
      mem[in_data.entry_index[cdrs_pkg::IDX_W-1:0]] <=
        '{setting: in_data.entry_setting, mul: in_data.entry_multiplier,
          dv: in_data.entry_divisor};
    end
    ent <= mem[cnt[cdrs_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= cdrs_pkg::MODE_PLAIN;
      field_width      <= 5'd4;
      entry_count      <= 5'd1;
      fixed_multiplier <= 16'd1;
      fixed_divisor    <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cdrs_pkg::REG_MODE:        mode             <= cfg_data[1:0];
        cdrs_pkg::REG_FIELD_WIDTH: field_width      <= cfg_data[4:0];
        cdrs_pkg::REG_ENTRY_COUNT: entry_count      <= cfg_data[4:0];
        cdrs_pkg::REG_FIXED_MUL:   fixed_multiplier <= cfg_data;
        cdrs_pkg::REG_FIXED_DIV:   fixed_divisor    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      // S_FIN drives out_valid itself when it hands over a beat
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= in_data.opcode;
            par   <= in_data.src_rate;
            tgt   <= (in_data.target_rate == '0) ? 32'd1 : in_data.target_rate;
            qset  <= in_data.query_setting;
            n     <= (entry_count > 5'(cdrs_pkg::TABLE_DEPTH)) ?
                     cdrs_pkg::CNT_W'(cdrs_pkg::TABLE_DEPTH) :
                     cdrs_pkg::CNT_W'(entry_count);
            state <= S_DISP;
          end
        end
        S_DISP: begin
          res_rate  <= '0;
          res_set   <= '0;
          res_valid <= 1'b0;
          cnt       <= '0;
          best_err  <= '1;
          top_rate  <= '0;
          best_set  <= '0;
          if (op == cdrs_pkg::OP_LOAD || op == cdrs_pkg::OP_NONE) begin
            state <= S_FIN;
          end else if (mode == cdrs_pkg::MODE_FIXED) begin
            if (par == '0 || fixed_divisor == '0) begin
              state <= S_FIN;
            end else begin
              mul_m <= fixed_multiplier;
              den_r <= 32'(fixed_divisor);
              state <= S_MUL;
            end
          end else if (mode == cdrs_pkg::MODE_PLAIN) begin
            if (op == cdrs_pkg::OP_FIND) begin
              if (par == '0) begin
                state <= S_FIN;
              end else begin
                num_r <= 48'(par) + 48'(tgt >> 1);
                den_r <= tgt;
                stage <= 1'b0;
                state <= S_DIV;
              end
            end else begin
              num_r <= 48'(par) + 48'((32'(qset) + 32'd1) >> 1);
              den_r <= 32'(qset) + 32'd1;
              stage <= 1'b1;
              state <= S_DIV;
            end
          end else begin
            if ((op == cdrs_pkg::OP_FIND && par == '0) || n == '0) state <= S_FIN;
            else state <= S_RD;
          end
        end
        S_RD: state <= S_ENT;
        S_ENT: begin
          if (op == cdrs_pkg::OP_FIND && ent.dv == '0) begin
            state <= S_FIN;
          end else if (op == cdrs_pkg::OP_RATE &&
                       !(ent.setting == qset && ent.dv != '0)) begin
            cnt <= cnt_inc;
            if (cnt_inc == n) state <= S_FIN;
            else state <= S_RD;
          end else begin
            den_r <= 32'(ent.dv);
            if (mode == cdrs_pkg::MODE_DIVTAB) begin
              num_r <= 48'(par) + 48'(ent.dv >> 1);
              state <= S_DIV;
            end else begin
              mul_m <= ent.mul;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          num_r <= prod;
          state <= S_DIV;
        end
        S_DIV: begin
          div_start <= 1'b1;
          state     <= S_WAIT;
        end
        S_WAIT: begin
          if (div_st.done) state <= S_EVAL;
        end
        S_EVAL: begin
          if (mode == cdrs_pkg::MODE_FIXED) begin
            res_rate <= quo;
            state    <= S_FIN;
          end else if (mode == cdrs_pkg::MODE_PLAIN) begin
            if (!stage) begin
              s_reg <= s_calc;
              num_r <= 48'(par) + 48'((32'(s_calc) + 32'd1) >> 1);
              den_r <= 32'(s_calc) + 32'd1;
              stage <= 1'b1;
              state <= S_DIV;
            end else begin
              res_rate <= quo;
              if (op == cdrs_pkg::OP_FIND && quo != '0) begin
                res_valid <= 1'b1;
                res_set   <= s_reg;
              end
              state <= S_FIN;
            end
          end else if (op == cdrs_pkg::OP_RATE) begin
            res_rate <= quo;
            state    <= S_FIN;
          end else begin
            // ties keep the earlier entry
            if (err < best_err) begin
              best_err  <= err;
              top_rate  <= quo;
              best_set  <= ent.setting;
            end
            cnt <= cnt_inc;
            if (cnt_inc == n) begin
              if (err < best_err) begin
                res_rate  <= quo;
                res_valid <= (quo != '0);
                res_set   <= (quo != '0) ? ent.setting : 16'd0;
              end else begin
                res_rate  <= top_rate;
                res_valid <= (top_rate != '0);
                res_set   <= (top_rate != '0) ? best_set : 16'd0;
              end
              state <= S_FIN;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid              <= 1'b1;
            out_data.rate_out      <= (res_rate[47:32] != '0) ? 32'hFFFF_FFFF :
                                      res_rate[31:0];
            out_data.setting_out   <= res_set;
            out_data.setting_valid <= res_valid;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall) else $error("input taken while busy");
  a_wait_to_eval: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT && div_st.done) |=> (state == S_EVAL))
    else $error("divide result missed");
  a_valid_rate: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.setting_valid) |-> (out_data.rate_out != '0))
    else $error("valid setting with zero rate");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.setting_valid) |-> (out_data.setting_out == '0))
    else $error("setting not cleared");

endmodule
